>>> sv/fnvpm_pkg.sv
`default_nettype none

package fnvpm_pkg;

  localparam int unsigned HashW       = 64;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned NarrowBytes = 2 * (ValueW / ByteW);
  // wide hash: four zero bytes, first value, four zero bytes, second value
  // (the leading four zero bytes are folded into the seed)
  localparam int unsigned NumCells    = 3 * (ValueW / ByteW);
  localparam int unsigned ShiftW      = NumCells * ByteW;

  localparam logic [HashW-1:0] FnvBasis    = 64'hCBF2_9CE4_8422_2325;
  // prime is 2^40 + 0x1B3
  localparam int unsigned      PrimeShift  = 40;
  localparam logic [8:0]       PrimeLow    = 9'h1B3;

  localparam logic [NumCells-1:0] NarrowMask =
    {{NarrowBytes{1'b1}}, {(NumCells - NarrowBytes){1'b0}}};

  typedef struct packed {
    logic [HashW-1:0]    acc_wide;
    logic [HashW-1:0]    acc_narrow;
    logic [ShiftW-1:0]   wide_sh;
    logic [ShiftW-1:0]   narrow_sh;
    logic [NumCells-1:0] narrow_en;
  } stage_t;

  function automatic logic [HashW-1:0] fnv_mix(input logic [HashW-1:0] acc,
                                               input logic [ByteW-1:0] octet);
    logic [HashW-1:0] x;
    x = acc ^ {{(HashW - ByteW){1'b0}}, octet};
    return (x << PrimeShift) + (x * {{(HashW - 9){1'b0}}, PrimeLow});
  endfunction

  function automatic logic [HashW-1:0] fnv_zero_seed();
    logic [HashW-1:0] h;
    h = FnvBasis;
    for (int i = 0; i < int'(ValueW / ByteW); i++) begin
      h = fnv_mix(h, '0);
    end
    return h;
  endfunction

  localparam logic [HashW-1:0] FnvWideSeed = fnv_zero_seed();

  localparam logic [3:0] AddrTarget = 4'h0;

endpackage

`default_nettype wire

>>> sv/fnvpm_cell.sv
`default_nettype none

module fnvpm_cell
  import fnvpm_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire stage_t in_data_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output stage_t      out_data_o
);

  logic   valid_q;
  stage_t data_q;
  stage_t data_d;

  always_comb begin
    data_d            = in_data_i;
    data_d.acc_wide   = fnv_mix(in_data_i.acc_wide, in_data_i.wide_sh[ShiftW-1 -: ByteW]);
    if (in_data_i.narrow_en[NumCells-1]) begin
      data_d.acc_narrow = fnv_mix(in_data_i.acc_narrow,
                                  in_data_i.narrow_sh[ShiftW-1 -: ByteW]);
    end
    data_d.wide_sh    = in_data_i.wide_sh << ByteW;
    data_d.narrow_sh  = in_data_i.narrow_sh << ByteW;
    data_d.narrow_en  = in_data_i.narrow_en << 1;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/fnv1a64_pair_match.sv
// Channel  Dir  Handshake          Payload (low bit up)
// s        in   s_tvalid/s_tready  s_tdata: first_value, second_value
// m        out  m_tvalid/m_tready  m_tdata: hash_wide, hash_narrow;
//                                  m_tuser: match_wide, match_narrow
// cfg      in   APB, pready = 1    0x0: target_hash (64 bits)
//
// One pair per cycle while m_tready keeps up; 12 hash cells, one byte per cell,
// then the compare/output register.
// Each stage holds while its successor is full, so bubbles close up under
// m_tready low; s_tready drops only when all 13 stages are full.
// rst_ni clears stage valids and target_hash.
`default_nettype none

module fnv1a64_pair_match
  import fnvpm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [2*ValueW-1:0]  s_tdata,   // first_value, second_value
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [2*HashW-1:0]        m_tdata,   // hash_wide, hash_narrow
  output logic [1:0]                m_tuser,   // match_wide, match_narrow
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [HashW-1:0]     pwdata,
  output logic [HashW-1:0]          prdata,
  output logic                      pready
);

  logic [HashW-1:0] target_q;
  logic             wr_target;

  stage_t             st  [NumCells+1];
  logic [NumCells:0]  vld;
  logic [NumCells:0]  rdy;

  logic               out_adv;
  logic [2*HashW-1:0] tdata_q;
  logic [1:0]         tuser_q;
  logic               tvalid_q;
  logic [ValueW-1:0]  first_value;
  logic [ValueW-1:0]  second_value;

  // config port
  assign pready    = 1'b1;
  assign wr_target = psel && penable && pwrite && (paddr[3] == AddrTarget[3]);
  assign prdata    = (paddr[3] == AddrTarget[3]) ? target_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (wr_target) begin
      target_q <= pwdata;
    end
  end

  // cell chain
  assign first_value  = s_tdata[ValueW-1:0];
  assign second_value = s_tdata[2*ValueW-1:ValueW];

  always_comb begin
    st[0].acc_wide   = FnvWideSeed;
    st[0].acc_narrow = FnvBasis;
    st[0].wide_sh    = {first_value, {ValueW{1'b0}}, second_value};
    st[0].narrow_sh  = {first_value, second_value, {ValueW{1'b0}}};
    st[0].narrow_en  = NarrowMask;
  end

  assign vld[0]   = s_tvalid;
  assign s_tready = rdy[0];

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    fnvpm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[k]),
      .in_ready_o  (rdy[k]),
      .in_data_i   (st[k]),
      .out_valid_o (vld[k+1]),
      .out_ready_i (rdy[k+1]),
      .out_data_o  (st[k+1])
    );
  end

  // compare and output register
  assign out_adv       = !tvalid_q || m_tready;
  assign rdy[NumCells] = out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (out_adv) begin
      tvalid_q <= vld[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && vld[NumCells]) begin
      tdata_q <= {st[NumCells].acc_narrow, st[NumCells].acc_wide};
      tuser_q <= {st[NumCells].acc_narrow == target_q,
                  st[NumCells].acc_wide == target_q};
    end
  end

  assign m_tvalid = tvalid_q;
  assign m_tdata  = tdata_q;
  assign m_tuser  = tuser_q;

`ifndef SYNTHESIS
  // back-pressure reaches the input only when every stage is occupied
  a_full_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready |-> (&vld[NumCells:1]) && tvalid_q && !m_tready)
    else $error("input stalled with a free stage");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> vld[1])
    else $error("accepted pair not in first cell");

  a_last_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[NumCells] && out_adv |=> tvalid_q)
    else $error("result lost at output register");

  a_cell_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[NumCells] && !out_adv |=> vld[NumCells] && $stable(st[NumCells].acc_wide))
    else $error("last cell changed while stalled");
`endif

endmodule

`default_nettype wire

>>> dv/tb_fnv1a64_pair_match.sv
`timescale 1ns / 1ps

module tb_fnv1a64_pair_match
  import fnvpm_pkg::*;
();

  localparam logic [63:0] OffsetBasis = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] FnvPrime64  = 64'h0000_0100_0000_01B3;
  localparam logic [3:0]  AddrUnused  = 4'h8;   // index 1: no register there
  localparam int          DrainCycles = 40;
  localparam int          NumPhases   = 6;
  localparam int          PhaseItems  = 200;

  typedef struct packed {
    logic [HashW-1:0] wide;
    logic [HashW-1:0] narrow;
    logic             match_w;
    logic             match_n;
  } pair_digest_t;

  typedef enum logic [2:0] {
    ROW_PAIR,
    ROW_AIM_WIDE,
    ROW_AIM_NARROW,
    ROW_AIM_VALUE,
    ROW_POKE_UNUSED
  } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [ValueW-1:0] a;
    logic [ValueW-1:0] b;
    logic [HashW-1:0]  value;
    bit                fixed;    // match flags below are known without hashing
    logic              fw;
    logic              fn;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni   = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [2*ValueW-1:0] s_tdata  = '0;      // first_value, second_value
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [2*HashW-1:0]  m_tdata;            // hash_wide, hash_narrow
  logic [1:0]          m_tuser;            // match_wide, match_narrow
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [3:0]          paddr    = '0;
  logic [HashW-1:0]    pwdata   = '0;
  logic [HashW-1:0]    prdata;
  logic                pready;

  logic [HashW-1:0] target_q = '0;
  pair_digest_t     digest_q[$];
  int               mismatch_count = 0;
  bit               calm = 1'b0;

  fnv1a64_pair_match dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [HashW-1:0] fold_word(input logic [HashW-1:0] acc,
                                                 input logic [ValueW-1:0] w,
                                                 input bit pad);
    logic [HashW-1:0] h;
    h = acc;
    if (pad) begin
      for (int k = 0; k < 4; k++) h = h * FnvPrime64;   // xor with zero byte
    end
    for (int k = 3; k >= 0; k--) begin
      h = (h ^ {56'd0, w[8*k +: 8]}) * FnvPrime64;
    end
    return h;
  endfunction

  function automatic pair_digest_t digest_pair(input logic [ValueW-1:0] a,
                                               input logic [ValueW-1:0] b);
    pair_digest_t d;
    d.wide    = fold_word(fold_word(OffsetBasis, a, 1'b1), b, 1'b1);
    d.narrow  = fold_word(fold_word(OffsetBasis, a, 1'b0), b, 1'b0);
    d.match_w = (d.wide == target_q);
    d.match_n = (d.narrow == target_q);
    return d;
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(9))
      4, 5, 6: return ValueW'($urandom_range(16384));   // the sweep box
      7:       return $urandom_range(1) ? '1 : '0;
      8:       return ValueW'(1) << $urandom_range(ValueW - 1);
      9:       return ~(ValueW'(1) << $urandom_range(ValueW - 1));
      default: return $urandom;
    endcase
  endfunction

  // result side: random stalls, checked in arrival order
  initial begin
    pair_digest_t d;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_tvalid && m_tready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected transfer: hash_wide %h", m_tdata[63:0]);
          mismatch_count++;
        end else begin
          d = digest_q.pop_front();
          if (m_tdata[63:0] !== d.wide) begin
            $error("hash_wide: expected %h, got %h", d.wide, m_tdata[63:0]);
            mismatch_count++;
          end
          if (m_tdata[127:64] !== d.narrow) begin
            $error("hash_narrow: expected %h, got %h", d.narrow, m_tdata[127:64]);
            mismatch_count++;
          end
          if (m_tuser[0] !== d.match_w) begin
            $error("match_wide: expected %b, got %b", d.match_w, m_tuser[0]);
            mismatch_count++;
          end
          if (m_tuser[1] !== d.match_n) begin
            $error("match_narrow: expected %b, got %b", d.match_n, m_tuser[1]);
            mismatch_count++;
          end
        end
      end
      m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
    end
  end

  task automatic send_pair(input logic [ValueW-1:0] a, input logic [ValueW-1:0] b,
                           input bit fixed, input logic fw, input logic fn);
    pair_digest_t d;
    if (!calm && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a};
    do @(posedge clk_i); while (!s_tready);
    d = digest_pair(a, b);
    if (fixed) begin
      d.match_w = fw;
      d.match_n = fn;
    end
    digest_q.push_back(d);
  endtask

  task automatic settle_pipeline();
    s_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write, then read the target back in the same bus tenure
  task automatic cfg_write(input logic [3:0] addr, input logic [HashW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == AddrTarget) target_q = data;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrTarget;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== target_q) begin
      $error("target_hash: expected %h, got %h", target_q, prdata);
      mismatch_count++;
    end
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    plan_row_t         plan[$];
    pair_digest_t      d;
    logic [ValueW-1:0] hit_a, hit_b, a, b;

    // target is zero out of reset, so the first rows cannot match
    plan.push_back('{ROW_PAIR, 32'h0000_0000, 32'h0000_0000, 64'h0, 1'b1, 1'b0, 1'b0});
    plan.push_back('{ROW_PAIR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0, 1'b1, 1'b0, 1'b0});
    plan.push_back('{ROW_PAIR, 32'h0000_0000, 32'hFFFF_FFFF, 64'h0, 1'b1, 1'b0, 1'b0});
    plan.push_back('{ROW_PAIR, 32'hFFFF_FFFF, 32'h0000_0000, 64'h0, 1'b1, 1'b0, 1'b0});
    plan.push_back('{ROW_PAIR, 32'h8000_0000, 32'h0000_0001, 64'h0, 1'b0, 1'b0, 1'b0});
    plan.push_back('{ROW_PAIR, 32'h0000_0001, 32'h8000_0000, 64'h0, 1'b0, 1'b0, 1'b0});
    plan.push_back('{ROW_PAIR, 32'h0102_0304, 32'hA0B0_C0D0, 64'h0, 1'b0, 1'b0, 1'b0});
    plan.push_back('{ROW_PAIR, 32'h0000_4000, 32'h0000_4000, 64'h0, 1'b0, 1'b0, 1'b0});
    plan.push_back('{ROW_AIM_WIDE, 32'h1234_5678, 32'h9ABC_DEF0, 64'h0, 1'b0, 1'b0, 1'b0});
    plan.push_back('{ROW_PAIR, 32'h1234_5678, 32'h9ABC_DEF0, 64'h0, 1'b0, 1'b0, 1'b0});
    plan.push_back('{ROW_PAIR, 32'h9ABC_DEF0, 32'h1234_5678, 64'h0, 1'b0, 1'b0, 1'b0});
    plan.push_back('{ROW_AIM_NARROW, 32'h0000_4000, 32'h0000_0000, 64'h0, 1'b0, 1'b0, 1'b0});
    plan.push_back('{ROW_PAIR, 32'h0000_4000, 32'h0000_0000, 64'h0, 1'b0, 1'b0, 1'b0});
    plan.push_back('{ROW_PAIR, 32'h0000_0000, 32'h0000_4000, 64'h0, 1'b0, 1'b0, 1'b0});
    // write to an unmapped index must leave the target alone
    plan.push_back('{ROW_POKE_UNUSED, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0});
    plan.push_back('{ROW_PAIR, 32'h0000_4000, 32'h0000_0000, 64'h0, 1'b0, 1'b0, 1'b0});
    plan.push_back('{ROW_AIM_VALUE, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0});
    plan.push_back('{ROW_PAIR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0, 1'b0, 1'b0, 1'b0});
    plan.push_back('{ROW_PAIR, 32'h5555_5555, 32'hAAAA_AAAA, 64'h0, 1'b0, 1'b0, 1'b0});
    plan.push_back('{ROW_AIM_VALUE, 32'h0, 32'h0, 64'h0, 1'b0, 1'b0, 1'b0});
    plan.push_back('{ROW_PAIR, 32'h0000_0000, 32'h0000_0000, 64'h0, 1'b0, 1'b0, 1'b0});
    plan.push_back('{ROW_PAIR, 32'hAAAA_AAAA, 32'h5555_5555, 64'h0, 1'b0, 1'b0, 1'b0});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_PAIR: send_pair(plan[i].a, plan[i].b, plan[i].fixed, plan[i].fw, plan[i].fn);
        ROW_AIM_WIDE, ROW_AIM_NARROW: begin
          settle_pipeline();
          d = digest_pair(plan[i].a, plan[i].b);
          cfg_write(AddrTarget, (plan[i].kind == ROW_AIM_WIDE) ? d.wide : d.narrow);
        end
        ROW_AIM_VALUE: begin
          settle_pipeline();
          cfg_write(AddrTarget, plan[i].value);
        end
        ROW_POKE_UNUSED: begin
          settle_pipeline();
          cfg_write(AddrUnused, plan[i].value);
        end
        default: ;
      endcase
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle_pipeline();
      hit_a = pick_value();
      hit_b = pick_value();
      d = digest_pair(hit_a, hit_b);
      case (ph % 4)
        0: cfg_write(AddrTarget, d.wide);
        1: cfg_write(AddrTarget, d.narrow);
        2: begin
          cfg_write(AddrUnused, {$urandom, $urandom});
          cfg_write(AddrTarget, {$urandom, $urandom});
        end
        default: cfg_write(AddrTarget, '1);
      endcase
      calm = (ph == 2);   // one phase runs back to back on both sides
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(99) < 8) begin
          a = hit_a;
          b = hit_b;
        end else begin
          a = pick_value();
          b = pick_value();
        end
        send_pair(a, b, 1'b0, 1'b0, 1'b0);
      end
      calm = 1'b0;
    end

    settle_pipeline();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
